/* src/urx_pkg.sv */
// shared types and constants for the uart header ping-pong page receiver
`timescale 1ns / 1ps

package urx_pkg;

    localparam int PAGE_BYTES_DEF   = 256;
    localparam int HEADER_BYTES_DEF = 3;

    localparam logic [15:0] PAGE_MAX = 16'hFFFF;
    localparam logic [23:0] LEN_MAX  = 24'hFF_FFFF;

    // request kinds on the input channel
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_IDLE = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } urx_item_t;

    typedef struct packed {
        logic        write_en;
        logic        write_bank;
        logic [7:0]  write_offset;
        logic [7:0]  write_byte;
        logic        header_done;
        logic [7:0]  command;
        logic [15:0] header_args;
        logic        page_ready;
        logic        ready_bank;
        logic        file_done;
        logic [15:0] file_pages;
        logic [23:0] file_bytes;
    } urx_result_t;

endpackage

/* src/urx_core.sv */
// receiver state and the single-pass result logic for one request
`timescale 1ns / 1ps

module urx_core
    import urx_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  urx_item_t   item,
    output urx_result_t res
);

    localparam int CNT_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAGE_BYTES - 1);
    localparam logic [1:0] HDR_LEN  = 2'(HEADER_BYTES);
    localparam logic [1:0] HDR_LAST = 2'(HEADER_BYTES - 1);
    localparam logic [24:0] PAGE_STEP = 25'(PAGE_BYTES);

    logic [1:0]       header_count_reg, header_count_next;
    logic [7:0]       header_bytes_reg [2];
    logic [7:0]       header_bytes_next [2];
    logic             bank_select_reg, bank_select_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]      page_count_reg, page_count_next;
    logic [23:0]      page_len_reg, page_len_next;
    logic             idle_armed_reg, idle_armed_next;

    logic [15:0] page_inc;
    logic [24:0] page_len_sum;
    logic [23:0] page_len_inc;
    logic [24:0] file_len_sum;
    logic [7:0]  h0, h1, h2;

    always_comb
    begin
        page_inc     = (page_count_reg == PAGE_MAX) ? PAGE_MAX : page_count_reg + 16'd1;
        page_len_sum = {1'b0, page_len_reg} + PAGE_STEP;
        // page_len tracks page_count * PAGE_BYTES, frozen once page_count saturates
        if (page_count_reg == PAGE_MAX)
            page_len_inc = page_len_reg;
        else if (page_len_sum > {1'b0, LEN_MAX})
            page_len_inc = LEN_MAX;
        else
            page_len_inc = page_len_sum[23:0];
        file_len_sum = {1'b0, page_len_reg} + 25'(byte_count_reg);

        h0 = (HEADER_BYTES >= 2) ? header_bytes_reg[0] : item.rx_byte;
        if (HEADER_BYTES >= 3)
            h1 = header_bytes_reg[1];
        else
            h1 = (HEADER_BYTES == 2) ? item.rx_byte : 8'd0;
        h2 = (HEADER_BYTES >= 3) ? item.rx_byte : 8'd0;
    end

    always_comb
    begin
        res                  = '0;
        header_count_next    = header_count_reg;
        header_bytes_next[0] = header_bytes_reg[0];
        header_bytes_next[1] = header_bytes_reg[1];
        bank_select_next     = bank_select_reg;
        byte_count_next      = byte_count_reg;
        page_count_next      = page_count_reg;
        page_len_next        = page_len_reg;
        idle_armed_next      = idle_armed_reg;

        if (item.func == FUNC_BYTE)
        begin
            if (header_count_reg < HDR_LEN)
            begin
                if (header_count_reg < 2'd2)
                    header_bytes_next[header_count_reg[0]] = item.rx_byte;
                if (header_count_reg == HDR_LAST)
                begin
                    res.header_done = 1'b1;
                    res.command     = h0;
                    res.header_args = {h1, h2};
                end
                header_count_next = header_count_reg + 2'd1;
            end
            else
            begin
                idle_armed_next  = 1'b1;
                res.write_en     = 1'b1;
                res.write_bank   = bank_select_reg;
                res.write_offset = 8'(byte_count_reg);
                res.write_byte   = item.rx_byte;
                if (byte_count_reg >= CNT_LAST)
                begin
                    page_count_next  = page_inc;
                    page_len_next    = page_len_inc;
                    byte_count_next  = '0;
                    res.page_ready   = 1'b1;
                    res.ready_bank   = bank_select_reg;
                    bank_select_next = ~bank_select_reg;
                end
                else
                begin
                    byte_count_next = byte_count_reg + CNT_W'(1);
                end
            end
        end
        else if (idle_armed_reg)
        begin
            idle_armed_next   = 1'b0;
            res.page_ready    = 1'b1;
            res.ready_bank    = bank_select_reg;
            res.file_done     = 1'b1;
            res.file_pages    = page_inc;
            res.file_bytes    = (file_len_sum > {1'b0, LEN_MAX}) ? LEN_MAX : file_len_sum[23:0];
            byte_count_next   = '0;
            page_count_next   = '0;
            page_len_next     = '0;
            header_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg    <= '0;
            header_bytes_reg[0] <= '0;
            header_bytes_reg[1] <= '0;
            bank_select_reg     <= 1'b0;
            byte_count_reg      <= '0;
            page_count_reg      <= '0;
            page_len_reg        <= '0;
            idle_armed_reg      <= 1'b0;
        end
        else if (step)
        begin
            header_count_reg    <= header_count_next;
            header_bytes_reg[0] <= header_bytes_next[0];
            header_bytes_reg[1] <= header_bytes_next[1];
            bank_select_reg     <= bank_select_next;
            byte_count_reg      <= byte_count_next;
            page_count_reg      <= page_count_next;
            page_len_reg        <= page_len_next;
            idle_armed_reg      <= idle_armed_next;
        end
    end

endmodule

/* src/uart_header_pingpong_page_receiver.sv */
// top level: input register, receiver core and result register
`timescale 1ns / 1ps

// uart header ping-pong page receiver. each request on the input channel is either a
// received byte (func 0) or a line-idle event (func 1), and each request gives exactly
// one result on the output channel. the first HEADER_BYTES bytes of a transfer form the
// header: the last of them pulses header_done with command and header_args. every later
// byte is a payload byte and comes out as a write (write_en, write_bank, write_offset,
// write_byte) into one of two page buffers; the byte that fills a page also pulses
// page_ready for that bank and the next byte goes to the other bank. an idle event counts
// only after at least one payload byte; it then flags the current bank ready, pulses
// file_done with the page count and byte length (both saturating) and restarts the
// header. throughput is one request per clock while out_ready keeps up; each request
// sits in the input register and its result is offered from the result register, with
// all state updated by one pass of logic between them. while a finished result waits
// for out_ready, the input register takes one more request and then holds in_ready low.
module uart_header_pingpong_page_receiver
    import urx_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        write_en,
    output logic        write_bank,
    output logic [7:0]  write_offset,
    output logic [7:0]  write_byte,
    output logic        header_done,
    output logic [7:0]  command,
    output logic [15:0] header_args,
    output logic        page_ready,
    output logic        ready_bank,
    output logic        file_done,
    output logic [15:0] file_pages,
    output logic [23:0] file_bytes
);

    // input register stage
    logic        s1_valid_reg, s1_valid_next;
    urx_item_t   s1_item_reg;

    // result register stage
    logic        out_valid_reg, out_valid_next;
    urx_result_t out_res_reg;

    urx_result_t core_res;
    logic        in_fire;
    logic        out_free;
    logic        s1_adv;

    // a request moves on whenever the result register is empty or being drained
    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_item_reg <= '{func: func, rx_byte: rx_byte};
        if (s1_adv)
            out_res_reg <= core_res;
    end

    // state advances exactly when a request enters the result register
    urx_core #(
        .PAGE_BYTES   (PAGE_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_adv),
        .item  (s1_item_reg),
        .res   (core_res)
    );

    assign out_valid    = out_valid_reg;
    assign write_en     = out_res_reg.write_en;
    assign write_bank   = out_res_reg.write_bank;
    assign write_offset = out_res_reg.write_offset;
    assign write_byte   = out_res_reg.write_byte;
    assign header_done  = out_res_reg.header_done;
    assign command      = out_res_reg.command;
    assign header_args  = out_res_reg.header_args;
    assign page_ready   = out_res_reg.page_ready;
    assign ready_bank   = out_res_reg.ready_bank;
    assign file_done    = out_res_reg.file_done;
    assign file_pages   = out_res_reg.file_pages;
    assign file_bytes   = out_res_reg.file_bytes;

`ifndef NO_ASSERTIONS
    // an empty result register never stalls the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("in_ready low with empty result register");

    // an honored idle event closes the bank and carries no write
    a_file_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.file_done) |->
        (out_res_reg.page_ready && !out_res_reg.write_en && !out_res_reg.header_done))
        else $error("file_done result malformed");

    // header results never overlap payload writes or page events
    a_header_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.header_done) |->
        (!out_res_reg.write_en && !out_res_reg.page_ready))
        else $error("header_done overlaps payload activity");

    // a request that entered the result register is offered on the next cycle
    a_adv_offered: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced request not offered");
`endif

endmodule

/* bench/uart_header_pingpong_page_receiver_tb.sv */
// testbench for the uart header ping-pong page receiver: directed and random requests
`timescale 1ns / 1ps

module uart_header_pingpong_page_receiver_tb;

    import urx_pkg::*;

    // block configuration, default parameters of the top level
    localparam int PAGE_LEN   = PAGE_BYTES_DEF;
    localparam int HDR_LEN    = HEADER_BYTES_DEF;
    localparam int HDR_STORED = 2;

    // cycles without any handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT = 1000;
    // input register plus result register, with some margin
    localparam int DRAIN_CYCLES   = 8;

    logic        clk;
    logic        rst_n;

    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [7:0]  rx_byte;

    logic        out_valid;
    logic        out_ready;
    logic        write_en;
    logic        write_bank;
    logic [7:0]  write_offset;
    logic [7:0]  write_byte;
    logic        header_done;
    logic [7:0]  command;
    logic [15:0] header_args;
    logic        page_ready;
    logic        ready_bank;
    logic        file_done;
    logic [15:0] file_pages;
    logic [23:0] file_bytes;

    // percentages of cycles in which the sender holds off or the receiver stalls
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatch_count = 0;
    int stall_cycles   = 0;

    // results predicted at request acceptance, oldest first
    urx_result_t expected_results[$];

    // predictor state: header progress, stored header bytes, active bank,
    // position in the page, pages so far and whether an idle would end the file
    int          hdr_count  = 0;
    logic [7:0]  hdr_seen[HDR_STORED] = '{8'h00, 8'h00};
    logic        bank       = 1'b0;
    int          byte_count = 0;
    logic [15:0] page_count = 16'h0000;
    logic        idle_armed = 1'b0;

    uart_header_pingpong_page_receiver i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_en     (write_en),
        .write_bank   (write_bank),
        .write_offset (write_offset),
        .write_byte   (write_byte),
        .header_done  (header_done),
        .command      (command),
        .header_args  (header_args),
        .page_ready   (page_ready),
        .ready_bank   (ready_bank),
        .file_done    (file_done),
        .file_pages   (file_pages),
        .file_bytes   (file_bytes)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // receiver side: out_ready changes on the falling edge only
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // works out the result of one request and advances the predictor state
    function automatic urx_result_t predict_result(input logic f, input logic [7:0] b);
        urx_result_t r;
        logic [31:0] len;
        r = '0;
        if (f == FUNC_BYTE)
        begin
            if (hdr_count < HDR_LEN)
            begin
                // header phase: the count stops at the header length
                if (hdr_count < HDR_STORED)
                    hdr_seen[hdr_count] = b;
                if (hdr_count == HDR_LEN - 1)
                begin
                    r.header_done = 1'b1;
                    r.command     = hdr_seen[0];
                    r.header_args = {hdr_seen[1], b};
                end
                hdr_count++;
            end
            else
            begin
                // payload byte: write request, and arm the idle event
                idle_armed     = 1'b1;
                r.write_en     = 1'b1;
                r.write_bank   = bank;
                r.write_offset = 8'(byte_count);
                r.write_byte   = b;
                if (byte_count >= PAGE_LEN - 1)
                begin
                    // page full: flag it and swap to the other bank
                    if (page_count != PAGE_MAX)
                        page_count++;
                    byte_count   = 0;
                    r.page_ready = 1'b1;
                    r.ready_bank = bank;
                    bank         = ~bank;
                end
                else
                    byte_count++;
            end
        end
        else if (idle_armed)
        begin
            // honored idle: last page ready, report length, restart header
            // an empty tail still counts as one more page
            idle_armed   = 1'b0;
            r.page_ready = 1'b1;
            r.ready_bank = bank;
            r.file_done  = 1'b1;
            r.file_pages = (page_count == PAGE_MAX) ? PAGE_MAX : page_count + 16'd1;
            len          = 32'(page_count) * PAGE_LEN + byte_count;
            r.file_bytes = (len > 32'(LEN_MAX)) ? LEN_MAX : len[23:0];
            byte_count   = 0;
            page_count   = 16'h0000;
            hdr_count    = 0;
            // bank is left as it is
        end
        // an idle that is not armed leaves everything alone, result all zero
        return r;
    endfunction

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker: every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        urx_result_t got;
        urx_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {write_en, write_bank, write_offset, write_byte, header_done, command,
                   header_args, page_ready, ready_bank, file_done, file_pages, file_bytes};
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("write_en",     want.write_en,     got.write_en);
                check_field("write_bank",   want.write_bank,   got.write_bank);
                check_field("write_offset", want.write_offset, got.write_offset);
                check_field("write_byte",   want.write_byte,   got.write_byte);
                check_field("header_done",  want.header_done,  got.header_done);
                check_field("command",      want.command,      got.command);
                check_field("header_args",  want.header_args,  got.header_args);
                check_field("page_ready",   want.page_ready,   got.page_ready);
                check_field("ready_bank",   want.ready_bank,   got.ready_bank);
                check_field("file_done",    want.file_done,    got.file_done);
                check_field("file_pages",   want.file_pages,   got.file_pages);
                check_field("file_bytes",   want.file_bytes,   got.file_bytes);
            end
        end
    end

    // watchdog: no handshake on either channel for too long means a hang
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
            $display("[uart_header_pingpong_page_receiver] ERROR");
            $finish;
        end
    end

    // one request: random hold-off, then valid held until accepted
    task automatic send_request(input logic f, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        func     = f;
        rx_byte  = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(predict_result(f, b));
    endtask

    // sender holds off until every predicted result has come out
    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // well-formed transfer: header, payload of the given length, idle
    task automatic send_transfer(input int payload_len);
        repeat (HDR_LEN)
            send_request(FUNC_BYTE, 8'($urandom_range(0, 255)));
        repeat (payload_len)
            send_request(FUNC_BYTE, 8'($urandom_range(0, 255)));
        send_request(FUNC_IDLE, 8'($urandom_range(0, 255)));
    endtask

    // idle events that nothing has armed: at reset, inside the header, right after it
    task automatic test_idle_unarmed();
        send_request(FUNC_IDLE, 8'hFF);
        send_request(FUNC_BYTE, 8'h00);
        send_request(FUNC_IDLE, 8'h00);
        send_request(FUNC_BYTE, 8'hFF);
        send_request(FUNC_BYTE, 8'h80);
        send_request(FUNC_IDLE, 8'h5A);
    endtask

    // short payload ended by idle, then a second idle that must be ignored
    task automatic test_short_file();
        send_request(FUNC_BYTE, 8'hFF);
        send_request(FUNC_BYTE, 8'h00);
        send_request(FUNC_BYTE, 8'h55);
        send_request(FUNC_BYTE, 8'hAA);
        send_request(FUNC_IDLE, 8'h00);
        send_request(FUNC_IDLE, 8'hFF);
    endtask

    // header bytes at their extremes, one payload byte
    task automatic test_header_extremes();
        send_request(FUNC_BYTE, 8'hFF);
        send_request(FUNC_BYTE, 8'h00);
        send_request(FUNC_BYTE, 8'hFF);
        send_request(FUNC_BYTE, 8'h01);
        send_request(FUNC_IDLE, 8'h00);
    endtask

    // exactly one full page, so the idle reports an empty tail page,
    // and the next transfers start in the other bank
    task automatic test_full_page_empty_tail();
        send_transfer(PAGE_LEN);
    endtask

    // mostly well-formed transfers with random content, plus stray idles,
    // broken headers and bursts of raw requests
    task automatic test_random_transfers(input int n_items);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                send_request(FUNC_IDLE, 8'($urandom_range(0, 255)));
            else if (pick < 12)
            begin
                // header cut short by an idle event
                len = $urandom_range(1, HDR_LEN - 1);
                repeat (len)
                    send_request(FUNC_BYTE, 8'($urandom_range(0, 255)));
                send_request(FUNC_IDLE, 8'($urandom_range(0, 255)));
                sent += len;
            end
            else if (pick < 20)
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                    send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                sent += len;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    len = PAGE_LEN;
                else if (pick < 10)
                    len = $urandom_range(PAGE_LEN - 6, PAGE_LEN + 6);
                else if (pick < 14)
                    len = 0;
                else
                    len = $urandom_range(1, 30);
                send_transfer(len);
                sent += len + HDR_LEN + 1;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FUNC_BYTE;
        rx_byte   = 8'h00;
        out_ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender rarely idles, receiver mostly stalls
        send_idle_pct  = 11;
        recv_stall_pct = 81;
        test_idle_unarmed();
        test_short_file();
        test_header_extremes();
        test_full_page_empty_tail();
        wait_for_results();

        // sender mostly idles, receiver rarely stalls
        send_idle_pct  = 81;
        recv_stall_pct = 11;
        test_random_transfers(120);
        wait_for_results();

        // full rate on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_transfers(120);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[uart_header_pingpong_page_receiver] OK");
        else
            $display("[uart_header_pingpong_page_receiver] ERROR");
        $finish;
    end

endmodule
